### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the grayscale converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define P2G_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("p2g assertion failed");

// cond must never be true outside reset
`define P2G_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("p2g forbidden condition seen");

`else

`define P2G_ASSERT(lbl, clk, rstn, prop)
`define P2G_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### rtl/core/p2g_pkg.sv
// ----------------------------------------------------------------------------
// p2g_pkg
// Types, modes and constants of the pixel to grayscale converter.
// ----------------------------------------------------------------------------
package p2g_pkg;

  typedef enum logic [1:0] {
    MODE_RGB        = 2'd0,
    MODE_PREMUL     = 2'd1,
    MODE_YUV_INT    = 2'd2,
    MODE_YUV_APPROX = 2'd3
  } conv_mode_t;

  // divider: two quotient bits per stage, eight quotient bits total
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = 8 / DIV_BITS_PER_STAGE;
  // front stage, divider stages, two luma stages
  localparam int NUM_STAGES         = DIV_STAGES + 3;
  localparam int LUMA_A_STAGE       = DIV_STAGES + 1;
  localparam int LUMA_B_STAGE       = DIV_STAGES + 2;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // YUV arithmetic width
  localparam int YUV_W = 20;

  localparam logic signed [YUV_W-1:0] K_Y_INT   = 298;
  localparam logic signed [YUV_W-1:0] K_R_INT   = 409;
  localparam logic signed [YUV_W-1:0] K_GU_INT  = 100;
  localparam logic signed [YUV_W-1:0] K_GV_INT  = 208;
  localparam logic signed [YUV_W-1:0] K_B_INT   = 516;
  localparam logic signed [YUV_W-1:0] K_R_Q10   = 1441;
  localparam logic signed [YUV_W-1:0] K_GU_Q10  = 354;
  localparam logic signed [YUV_W-1:0] K_GV_Q10  = 734;
  localparam logic signed [YUV_W-1:0] K_B_Q10   = 1822;
  localparam logic signed [YUV_W-1:0] OFS_Y     = 16;
  localparam logic signed [YUV_W-1:0] OFS_C     = 128;
  localparam logic signed [YUV_W-1:0] RND_INT   = 128;
  localparam logic signed [YUV_W-1:0] MAX8      = 255;

  // gray weights, Q10
  localparam logic [9:0] W_R      = 10'd306;
  localparam logic [9:0] W_G      = 10'd601;
  localparam logic [9:0] W_B      = 10'd117;
  localparam logic [9:0] LUMA_RND = 10'd512;

endpackage

### rtl/core/pixel_to_grayscale_converter.sv
// ----------------------------------------------------------------------------
// pixel_to_grayscale_converter
// Takes one item per cycle while the output is not stalled.
// Depth set by the 4-stage radix-4 unpremultiply divider plus a front stage
// and two gray weighting stages. Empty stages fill while the output stalls.
// Reset clears all stage valid bits and sets the mode to plain RGB.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_to_grayscale_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_first_chan,
  input  logic [7:0] in_second_chan,
  input  logic [7:0] in_third_chan,
  input  logic [7:0] in_alpha_chan,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_gray_value
);
  import p2g_pkg::*;

  typedef struct packed {
    rgb_t       chan;
    conv_mode_t mode;
  } pix_t;

  conv_mode_t          conv_mode_r;
  stage_en_t           vld_r;
  stage_en_t           vld_in;
  stage_en_t           stage_en;
  logic [NUM_STAGES:0] rdy;
  pix_t                pix_r [0:DIV_STAGES];
  rgb_t                div_rgb;
  rgb_t                yuv_rgb;
  rgb_t                sel_rgb;
  logic                in_acc;
  logic                out_acc;
  int                  occ;
  int                  occ_exp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_mode_r <= MODE_RGB;
    end else if (cfg_wr_en) begin
      conv_mode_r <= conv_mode_t'(cfg_wr_data);
    end
  end

  // a stage loads when empty or when its content moves on
  always_comb begin
    rdy[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    stage_en = rdy[NUM_STAGES-1:0];
    vld_in   = {vld_r[NUM_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pix_r[0] <= '{chan: '{r: in_first_chan, g: in_second_chan, b: in_third_chan},
                    mode: conv_mode_r};
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (stage_en[k]) begin
        pix_r[k] <= pix_r[k-1];
      end
    end
  end

  p2g_div u_div_r (
    .clk      (clk),
    .stage_en (stage_en),
    .chan     (in_first_chan),
    .alpha    (in_alpha_chan),
    .quo      (div_rgb.r)
  );

  p2g_div u_div_g (
    .clk      (clk),
    .stage_en (stage_en),
    .chan     (in_second_chan),
    .alpha    (in_alpha_chan),
    .quo      (div_rgb.g)
  );

  p2g_div u_div_b (
    .clk      (clk),
    .stage_en (stage_en),
    .chan     (in_third_chan),
    .alpha    (in_alpha_chan),
    .quo      (div_rgb.b)
  );

  p2g_yuv u_yuv (
    .clk      (clk),
    .stage_en (stage_en),
    .mode     (conv_mode_r),
    .y_in     (in_first_chan),
    .u_in     (in_second_chan),
    .v_in     (in_third_chan),
    .rgb      (yuv_rgb)
  );

  always_comb begin
    case (pix_r[DIV_STAGES].mode)
      MODE_RGB:                      sel_rgb = pix_r[DIV_STAGES].chan;
      MODE_PREMUL:                   sel_rgb = div_rgb;
      MODE_YUV_INT, MODE_YUV_APPROX: sel_rgb = yuv_rgb;
      default:                       sel_rgb = pix_r[DIV_STAGES].chan;
    endcase
  end

  p2g_luma u_luma (
    .clk      (clk),
    .stage_en (stage_en),
    .rgb_in   (sel_rgb),
    .gray     (out_gray_value)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign occ       = $countones(vld_r);
  assign occ_exp   = occ + int'(in_acc) - int'(out_acc);

  // input only backs up once every stage holds an item
  `P2G_ASSERT_NEVER(a_stall_with_bubble, clk, rst_n, in_stall && !(&vld_r))
  // items in flight change only by accepts on either side
  `P2G_ASSERT(a_item_count, clk, rst_n, 1'b1 |=> (occ == $past(occ_exp)))
  // a held result stays put while stalled
  `P2G_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_gray_value)))

endmodule

### rtl/core/p2g_div.sv
// ----------------------------------------------------------------------------
// p2g_div
// Pipelined unpremultiply: (chan*255)/alpha, saturated at 255, zero on
// zero alpha. Restoring division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module p2g_div (
  input  logic                clk,
  input  p2g_pkg::stage_en_t  stage_en,
  input  logic [7:0]          chan,
  input  logic [7:0]          alpha,
  output logic [7:0]          quo
);
  import p2g_pkg::*;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
    logic [7:0] dvs;
    logic       force_hi;
    logic       force_zero;
  } div_st_t;

  function automatic div_st_t div_advance(div_st_t s);
    div_st_t    t;
    logic [8:0] trial;
    t = s;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      trial = {t.rem, t.low[7]};
      t.low = {t.low[6:0], 1'b0};
      if (trial >= {1'b0, t.dvs}) begin
        trial = trial - {1'b0, t.dvs};
        t.quo = {t.quo[6:0], 1'b1};
      end else begin
        t.quo = {t.quo[6:0], 1'b0};
      end
      t.rem = trial[7:0];
    end
    return t;
  endfunction

  div_st_t     st_r [0:DIV_STAGES];
  div_st_t     front_nxt;
  logic [15:0] num;

  // chan < alpha keeps the quotient below 256 and the top byte below alpha
  always_comb begin
    num                  = {chan, 8'h00} - {8'h00, chan};
    front_nxt.rem        = num[15:8];
    front_nxt.low        = num[7:0];
    front_nxt.quo        = '0;
    front_nxt.dvs        = alpha;
    front_nxt.force_hi   = (chan >= alpha);
    front_nxt.force_zero = (alpha == 8'h00);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      st_r[0] <= front_nxt;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (stage_en[k]) begin
        st_r[k] <= div_advance(st_r[k-1]);
      end
    end
  end

  always_comb begin
    if (st_r[DIV_STAGES].force_zero) begin
      quo = 8'h00;
    end else if (st_r[DIV_STAGES].force_hi) begin
      quo = 8'hFF;
    end else begin
      quo = st_r[DIV_STAGES].quo;
    end
  end

endmodule

### rtl/core/p2g_yuv.sv
// ----------------------------------------------------------------------------
// p2g_yuv
// YUV to RGB for the integer BT.601 and the Q10 approximate paths, with
// clamping, delayed to line up with the divider.
// ----------------------------------------------------------------------------
module p2g_yuv (
  input  logic                clk,
  input  p2g_pkg::stage_en_t  stage_en,
  input  p2g_pkg::conv_mode_t mode,
  input  logic [7:0]          y_in,
  input  logic [7:0]          u_in,
  input  logic [7:0]          v_in,
  output p2g_pkg::rgb_t       rgb
);
  import p2g_pkg::*;

  function automatic logic [7:0] clamp8(logic signed [YUV_W-1:0] x);
    if (x < 0) begin
      return 8'h00;
    end else if (x > MAX8) begin
      return 8'hFF;
    end else begin
      return x[7:0];
    end
  endfunction

  logic                    approx;
  logic signed [YUV_W-1:0] y_s, d_s, e_s;
  logic signed [YUV_W-1:0] base_nxt, rt_nxt, gt_nxt, bt_nxt;
  logic signed [YUV_W-1:0] base_r, rt_r, gt_r, bt_r;
  logic                    approx_r;
  logic signed [YUV_W-1:0] sum_r, sum_g, sum_b;
  rgb_t                    rgb_nxt;
  rgb_t                    rgb_r [1:DIV_STAGES];

  always_comb begin
    approx = (mode == MODE_YUV_APPROX);
    y_s    = $signed({{(YUV_W-8){1'b0}}, y_in});
    d_s    = $signed({{(YUV_W-8){1'b0}}, u_in}) - OFS_C;
    e_s    = $signed({{(YUV_W-8){1'b0}}, v_in}) - OFS_C;
    if (approx) begin
      base_nxt = y_s <<< 10;
      rt_nxt   = K_R_Q10 * e_s;
      gt_nxt   = -((K_GU_Q10 * d_s) + (K_GV_Q10 * e_s));
      bt_nxt   = K_B_Q10 * d_s;
    end else begin
      base_nxt = (K_Y_INT * (y_s - OFS_Y)) + RND_INT;
      rt_nxt   = K_R_INT * e_s;
      gt_nxt   = -((K_GU_INT * d_s) + (K_GV_INT * e_s));
      bt_nxt   = K_B_INT * d_s;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      base_r   <= base_nxt;
      rt_r     <= rt_nxt;
      gt_r     <= gt_nxt;
      bt_r     <= bt_nxt;
      approx_r <= approx;
    end
  end

  // floor shift then clamp
  always_comb begin
    sum_r = base_r + rt_r;
    sum_g = base_r + gt_r;
    sum_b = base_r + bt_r;
    if (approx_r) begin
      rgb_nxt.r = clamp8(sum_r >>> 10);
      rgb_nxt.g = clamp8(sum_g >>> 10);
      rgb_nxt.b = clamp8(sum_b >>> 10);
    end else begin
      rgb_nxt.r = clamp8(sum_r >>> 8);
      rgb_nxt.g = clamp8(sum_g >>> 8);
      rgb_nxt.b = clamp8(sum_b >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      rgb_r[1] <= rgb_nxt;
    end
    for (int k = 2; k <= DIV_STAGES; k++) begin
      if (stage_en[k]) begin
        rgb_r[k] <= rgb_r[k-1];
      end
    end
  end

  assign rgb = rgb_r[DIV_STAGES];

endmodule

### rtl/core/p2g_luma.sv
// ----------------------------------------------------------------------------
// p2g_luma
// Gray weighting (306R + 601G + 117B + 512) >> 10 in two stages.
// ----------------------------------------------------------------------------
module p2g_luma (
  input  logic               clk,
  input  p2g_pkg::stage_en_t stage_en,
  input  p2g_pkg::rgb_t      rgb_in,
  output logic [7:0]         gray
);
  import p2g_pkg::*;

  logic [16:0] pr_nxt, pr_r;
  logic [17:0] pg_nxt, pg_r;
  logic [14:0] pb_nxt, pb_r;
  logic [17:0] sum;
  logic [7:0]  gray_r;

  always_comb begin
    pr_nxt = 17'(rgb_in.r) * 17'(W_R);
    pg_nxt = 18'(rgb_in.g) * 18'(W_G);
    pb_nxt = 15'(rgb_in.b) * 15'(W_B);
    sum    = 18'(pr_r) + pg_r + 18'(pb_r) + 18'(LUMA_RND);
  end

  always_ff @(posedge clk) begin
    if (stage_en[LUMA_A_STAGE]) begin
      pr_r <= pr_nxt;
      pg_r <= pg_nxt;
      pb_r <= pb_nxt;
    end
    if (stage_en[LUMA_B_STAGE]) begin
      gray_r <= sum[17:10];
    end
  end

  assign gray = gray_r;

endmodule

### test/tb_pixel_to_grayscale_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_to_grayscale_converter
// Self-checking bench for the grayscale converter. Pixels are fed from a
// queue under random input gaps and output stalls. Each accepted pixel is
// scored against an in-bench gray computation for the mode it was sent
// under. The mode changes only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_pixel_to_grayscale_converter;
  import p2g_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int PIPE_SETTLE    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 82;

  typedef struct {
    conv_mode_t mode;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] a;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_first_chan = 8'd0;
  logic [7:0] in_second_chan = 8'd0;
  logic [7:0] in_third_chan = 8'd0;
  logic [7:0] in_alpha_chan = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_gray_value;

  pixel_t     pixels_pending[$];
  logic [7:0] gray_expected[$];
  pixel_t     px_on_bus;
  int         errors = 0;
  int         tx_wait = 0;
  int         rx_wait = 0;
  int         results_seen = 0;
  int         idle_cycles = 0;
  bit         tx_burst = 1'b0;
  bit         rx_burst = 1'b0;

  pixel_to_grayscale_converter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_first_chan  (in_first_chan),
    .in_second_chan (in_second_chan),
    .in_third_chan  (in_third_chan),
    .in_alpha_chan  (in_alpha_chan),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gray_value (out_gray_value)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int clamp_byte(int x);
    if (x < 0) return 0;
    if (x > 255) return 255;
    return x;
  endfunction

  function automatic int unpremultiply(int c, int a);
    int q;
    if (a == 0) return 0;
    q = (c * 255) / a;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic logic [7:0] gray_of(pixel_t p);
    int r, g, b, y, d, e;
    d = int'(p.c1) - 128;
    e = int'(p.c2) - 128;
    case (p.mode)
      MODE_RGB: begin
        r = p.c0; g = p.c1; b = p.c2;
      end
      MODE_PREMUL: begin
        r = unpremultiply(p.c0, p.a);
        g = unpremultiply(p.c1, p.a);
        b = unpremultiply(p.c2, p.a);
      end
      MODE_YUV_INT: begin
        y = 298 * (int'(p.c0) - 16);
        r = clamp_byte((y + 409 * e + 128) >>> 8);
        g = clamp_byte((y - 100 * d - 208 * e + 128) >>> 8);
        b = clamp_byte((y + 516 * d + 128) >>> 8);
      end
      default: begin
        y = int'(p.c0) * 1024;
        r = clamp_byte((y + 1441 * e) >>> 10);
        g = clamp_byte((y - 354 * d - 734 * e) >>> 10);
        b = clamp_byte((y + 1822 * d) >>> 10);
      end
    endcase
    return 8'((306 * r + 601 * g + 117 * b + 512) >> 10);
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        gray_expected.push_back(gray_of(px_on_bus));
        tx_wait = tx_burst ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pixels_pending.size() > 0) begin
          px_on_bus = pixels_pending.pop_front();
          in_first_chan  <= px_on_bus.c0;
          in_second_chan <= px_on_bus.c1;
          in_third_chan  <= px_on_bus.c2;
          in_alpha_chan  <= px_on_bus.a;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; a long hold-off now and then backs up the pipe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gray_expected.size() == 0) begin
          flag_error($sformatf("unexpected gray item %0d", out_gray_value));
        end else begin
          logic [7:0] want;
          want = gray_expected.pop_front();
          if (out_gray_value !== want)
            flag_error($sformatf("gray_value got %0d want %0d", out_gray_value, want));
        end
        results_seen++;
        if (results_seen % 300 == 150) rx_wait = LONG_HOLD;
        else rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("pixel_to_grayscale_converter verification failed");
        $finish;
      end
    end
  end

  task automatic queue_px(conv_mode_t m, int c0, int c1, int c2, int a);
    pixel_t p;
    p.mode = m;
    p.c0 = 8'(c0);
    p.c1 = 8'(c1);
    p.c2 = 8'(c2);
    p.a  = 8'(a);
    pixels_pending.push_back(p);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pixels_pending.size() != 0 || in_valid || gray_expected.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(conv_mode_t m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic queue_random(conv_mode_t m);
    int a, sel;
    sel = $urandom_range(0, 9);
    a = $urandom_range(0, 255);
    if (m == MODE_PREMUL && sel == 0)
      queue_px(m, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 0);
    else if (m == MODE_PREMUL && sel < 7)
      // well-formed: no channel above alpha
      queue_px(m, $urandom_range(0, a), $urandom_range(0, a), $urandom_range(0, a), a);
    else
      queue_px(m, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), a);
  endtask

  initial begin
    conv_mode_t m;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(MODE_RGB);
    queue_px(MODE_RGB, 0, 0, 0, 0);
    queue_px(MODE_RGB, 255, 255, 255, 255);
    queue_px(MODE_RGB, 255, 0, 170, 85);

    set_mode(MODE_PREMUL);
    queue_px(MODE_PREMUL, 255, 255, 255, 0);
    queue_px(MODE_PREMUL, 200, 100, 50, 10);
    queue_px(MODE_PREMUL, 255, 255, 255, 255);
    queue_px(MODE_PREMUL, 0, 0, 0, 255);
    queue_px(MODE_PREMUL, 128, 64, 255, 128);
    queue_px(MODE_PREMUL, 1, 0, 1, 1);

    set_mode(MODE_YUV_INT);
    queue_px(MODE_YUV_INT, 0, 0, 0, 0);
    queue_px(MODE_YUV_INT, 255, 255, 255, 255);
    queue_px(MODE_YUV_INT, 16, 128, 128, 0);
    queue_px(MODE_YUV_INT, 255, 0, 255, 0);
    queue_px(MODE_YUV_INT, 0, 255, 0, 0);

    set_mode(MODE_YUV_APPROX);
    queue_px(MODE_YUV_APPROX, 0, 0, 0, 0);
    queue_px(MODE_YUV_APPROX, 255, 255, 255, 255);
    queue_px(MODE_YUV_APPROX, 128, 128, 128, 0);
    queue_px(MODE_YUV_APPROX, 0, 255, 255, 0);
    queue_px(MODE_YUV_APPROX, 255, 0, 0, 0);
    queue_px(MODE_YUV_APPROX, 0, 0, 255, 0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      m = (p < 4) ? conv_mode_t'(3 - p) : conv_mode_t'($urandom_range(0, 3));
      set_mode(m);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) queue_random(m);
    end

    drain();
    if (errors == 0) begin
      $display("pixel_to_grayscale_converter verification clean");
    end else begin
      $display("pixel_to_grayscale_converter verification failed");
    end
    $finish;
  end

endmodule

### pixel_to_grayscale_converter.f
+incdir+rtl/core
rtl/core/p2g_pkg.sv
rtl/core/p2g_div.sv
rtl/core/p2g_yuv.sv
rtl/core/p2g_luma.sv
rtl/core/pixel_to_grayscale_converter.sv
test/tb_pixel_to_grayscale_converter.sv
